### design/t1brc_pkg.sv
`timescale 1ns / 1ps

package t1brc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegSentNad   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIfsdLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEdcMode   = 2'd2;

  localparam logic [7:0] IfsdLimitRst = 8'd32;

  // EDC kinds
  localparam logic EdcLrc = 1'b0;
  localparam logic EdcCrc = 1'b1;

  // CRC-16 CCITT, MSB first
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Block rule masks
  localparam logic [7:0] NadRsvMask  = 8'h88;
  localparam logic [7:0] NadBcast    = 8'hFF;
  localparam logic [7:0] PcbSBit     = 8'h80;
  localparam logic [7:0] PcbRBit     = 8'h40;
  localparam logic [7:0] PcbSRsvMask = 8'h1F;
  localparam logic [7:0] PcbRRsvMask = 8'h1C;
  localparam logic [7:0] PcbIRsvMask = 8'h2C;
  localparam logic [7:0] LenRsv      = 8'hFF;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StBadEdc = 3'd1,
    StBadNad = 3'd2,
    StBadPcb = 3'd3,
    StBadLen = 3'd4,
    StLink   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] sent_nad;
    logic [7:0] ifsd_limit;
    logic       edc_mode;
  } cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic       link;
    logic [7:0] data;
  } item_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic status_e block_rules(input logic [7:0] nad, input logic [7:0] pcb,
                                          input logic [7:0] len, input logic [7:0] limit);
    status_e st;
    st = StOk;
    if (nad == 8'h00) begin
      st = StOk;
    end else if (nad == NadBcast || (nad & NadRsvMask) != 8'h00 || nad[7:4] == nad[3:0]) begin
      st = StBadNad;
    end else if ((pcb & PcbSBit) != 8'h00) begin
      if ((pcb & PcbSRsvMask) != 8'h00) st = StBadPcb;
    end else if ((pcb & PcbRBit) != 8'h00) begin
      if ((pcb & PcbRRsvMask) != 8'h00) st = StBadPcb;
    end else begin
      if ((pcb & PcbIRsvMask) != 8'h00) st = StBadPcb;
      else if (len != 8'h00) st = StBadLen;
    end
    if (st == StOk && nad != 8'h00) begin
      if (len == LenRsv || len > limit) st = StBadLen;
    end
    return st;
  endfunction

endpackage

### design/t1brc_in_if.sv
`timescale 1ns / 1ps

interface t1brc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_error;

  modport source (output valid, output data_byte, output line_error, input ready);
  modport sink (input valid, input data_byte, input line_error, output ready);
endinterface

### design/t1brc_out_if.sv
`timescale 1ns / 1ps

interface t1brc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [8:0] byte_index;
  logic       block_done;
  logic [2:0] status;

  modport source (output valid, output byte_out, output byte_index, output block_done,
                  output status, input ready);
  modport sink (input valid, input byte_out, input byte_index, input block_done,
                input status, output ready);
endinterface

### design/t1_block_receive_checker.sv
`timescale 1ns / 1ps

// T=1 block receive checker. Feed the bytes of one received block (NAD, PCB,
// LEN, LEN information bytes, then one LRC byte or two CRC-16 bytes high byte
// first) one request each on in_if; set line_error instead of a byte when the
// link reports a timeout or failure. Every request yields exactly one result
// on out_if carrying the byte, its position in the block and, on the last
// epilogue byte or on a link error, block_done with the final status
// (0 ok, 1 bad EDC, 2 bad NAD, 3 bad PCB, 4 bad LEN, 5 link error). Checks run
// EDC first, then the received NAD against sent_nad with its nibbles swapped,
// then the NAD/PCB/LEN block rules against ifsd_limit. A new block starts on
// the byte after any final result. Throughput is one byte per clock while
// out_if does not stall: the LRC/CRC update and the final status are resolved
// combinationally in the back end. A result passes the front register, the
// two-entry queue and the output register; out_if stalls hold it there.
// Registers (cfg_idx_i): 0 sent_nad, 1 ifsd_limit (reset 32), 2 edc_mode
// (0 LRC, 1 CRC, sampled at the first epilogue byte); write only while idle.

module t1_block_receive_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [t1brc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i,
  t1brc_in_if.sink                        in_if,
  t1brc_out_if.source                     out_if
);
  import t1brc_pkg::*;

  // Configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSentNad:   cfg_d.sent_nad   = cfg_wdata_i;
        RegIfsdLimit: cfg_d.ifsd_limit = cfg_wdata_i;
        RegEdcMode:   cfg_d.edc_mode   = cfg_wdata_i[0];
        default:      cfg_d = cfg_q;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sent_nad   <= 8'h00;
      cfg_q.ifsd_limit <= IfsdLimitRst;
      cfg_q.edc_mode   <= EdcLrc;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front -> queue -> back
  logic  fr_valid, fr_ready;
  item_t fr_item;
  logic  q_valid, q_ready;
  item_t q_item;

  // front: accepts requests and tags link errors
  t1brc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .push_valid_o (fr_valid),
    .push_ready_i (fr_ready),
    .push_item_o  (fr_item)
  );

  // short queue so front and back stall independently
  t1brc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // back: block state, EDC accumulation, final status, output register
  t1brc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_item_i  (q_item),
    .out_if      (out_if)
  );

endmodule

### design/t1brc_queue.sv
`timescale 1ns / 1ps

module t1brc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  t1brc_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output t1brc_pkg::item_t pop_item_o
);
  import t1brc_pkg::*;

  // two-entry queue
  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) count_d = count_q + 2'd1;
    else if (pop && !push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

### design/t1brc_front.sv
`timescale 1ns / 1ps

module t1brc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  t1brc_in_if.sink        in_if,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output t1brc_pkg::item_t push_item_o
);
  import t1brc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_if.ready  = !valid_q || push_ready_i;
  assign take         = in_if.valid && in_if.ready;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // a link error carries no byte: pass it on as zero
  always_comb begin
    item_d.link = in_if.line_error;
    item_d.data = in_if.line_error ? 8'h00 : in_if.data_byte;
    valid_d     = take || (valid_q && !push_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_d;
  end

endmodule

### design/t1brc_back.sv
`timescale 1ns / 1ps

module t1brc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  t1brc_pkg::cfg_t  cfg_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  t1brc_pkg::item_t pop_item_i,
  t1brc_out_if.source      out_if
);
  import t1brc_pkg::*;

  localparam logic [1:0] PhPrologue = 2'd0;
  localparam logic [1:0] PhInfo     = 2'd1;
  localparam logic [1:0] PhEdcFirst = 2'd2;
  localparam logic [1:0] PhCrcLow   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [8:0]  byte_count_q, byte_count_d;
  logic [7:0]  nad_q, nad_d;
  logic [7:0]  pcb_q, pcb_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  lrc_q, lrc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_out_q;
  logic [8:0]  byte_index_q;
  logic        done_q;
  status_e     status_q;

  logic        take;
  logic        done;
  status_e     st;
  logic        edc_ok;
  logic        edc_final;
  logic [7:0]  b;
  logic [7:0]  swapped;
  logic [9:0]  info_end;

  assign pop_ready_o = !out_valid_q || out_if.ready;
  assign take        = pop_valid_i && pop_ready_o;
  assign b           = pop_item_i.data;
  assign swapped     = {cfg_i.sent_nad[3:0], cfg_i.sent_nad[7:4]};
  assign info_end    = 10'd2 + {2'b00, len_q};

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q + 9'd1;
    nad_d        = nad_q;
    pcb_d        = pcb_q;
    len_d        = len_q;
    lrc_d        = lrc_q;
    crc_d        = crc_q;
    crc_hi_d     = crc_hi_q;
    done         = 1'b0;
    edc_final    = 1'b0;
    edc_ok       = 1'b0;
    st           = StOk;

    if (pop_item_i.link) begin
      done = 1'b1;
      st   = StLink;
    end else begin
      unique case (phase_q)
        PhPrologue: begin
          if (byte_count_q == 9'd0) begin
            nad_d = b;
          end else if (byte_count_q == 9'd1) begin
            pcb_d = b;
          end else begin
            len_d   = b;
            phase_d = (b == 8'h00) ? PhEdcFirst : PhInfo;
          end
          lrc_d = lrc_q ^ b;
          crc_d = crc_update(crc_q, b);
        end
        PhInfo: begin
          lrc_d = lrc_q ^ b;
          crc_d = crc_update(crc_q, b);
          if ({1'b0, byte_count_q} >= info_end) phase_d = PhEdcFirst;
        end
        PhEdcFirst: begin
          if (cfg_i.edc_mode == EdcLrc) begin
            edc_final = 1'b1;
            edc_ok    = (b == lrc_q);
          end else begin
            crc_hi_d = b;
            phase_d  = PhCrcLow;
          end
        end
        PhCrcLow: begin
          edc_final = 1'b1;
          edc_ok    = ({crc_hi_q, b} == crc_q);
        end
        default: begin
          phase_d = PhPrologue;
        end
      endcase

      if (edc_final) begin
        done = 1'b1;
        if (!edc_ok) st = StBadEdc;
        else if (nad_q != swapped) st = StBadNad;
        else st = block_rules(nad_q, pcb_q, len_q, cfg_i.ifsd_limit);
      end
    end

    // end of block or link error: back to the start of a block
    if (done) begin
      phase_d      = PhPrologue;
      byte_count_d = 9'd0;
      nad_d        = 8'h00;
      pcb_d        = 8'h00;
      len_d        = 8'h00;
      lrc_d        = 8'h00;
      crc_d        = CrcInit;
      crc_hi_d     = 8'h00;
    end

    out_valid_d = take || (out_valid_q && !out_if.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhPrologue;
      byte_count_q <= 9'd0;
      nad_q        <= 8'h00;
      pcb_q        <= 8'h00;
      len_q        <= 8'h00;
      lrc_q        <= 8'h00;
      crc_q        <= CrcInit;
      crc_hi_q     <= 8'h00;
      out_valid_q  <= 1'b0;
    end else begin
      if (take) begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
        nad_q        <= nad_d;
        pcb_q        <= pcb_d;
        len_q        <= len_d;
        lrc_q        <= lrc_d;
        crc_q        <= crc_d;
        crc_hi_q     <= crc_hi_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_out_q   <= b;
      byte_index_q <= byte_count_q;
      done_q       <= done;
      status_q     <= st;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.byte_out   = byte_out_q;
  assign out_if.byte_index = byte_index_q;
  assign out_if.block_done = done_q;
  assign out_if.status     = status_q;

`ifndef SYNTHESIS
  a_status_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !done_q |-> status_q == StOk)
    else $error("status set on a byte that does not end the block");

  a_link_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == StLink |-> done_q && byte_out_q == 8'h00)
    else $error("link error result malformed");

  a_prologue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPrologue |-> byte_count_q <= 9'd2)
    else $error("prologue phase beyond third byte");

  a_clear_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && done |=> byte_count_q == 9'd0 && phase_q == PhPrologue && crc_q == CrcInit)
    else $error("block state not cleared after final byte");
`endif

endmodule

### sim/t1_block_receive_checker_test.sv
`timescale 1ns / 1ps

module t1_block_receive_checker_test;
  import t1brc_pkg::*;

  // Phase of the block being received, as tracked by the scoreboard model
  typedef enum logic [1:0] {
    RxHeader,
    RxInfo,
    RxEdc,
    RxCrcLo
  } rx_phase_e;

  // Where a driven byte comes from: a literal, or the check bytes of the
  // running block, so good epilogues can be built on the fly
  typedef enum logic [1:0] {
    FillLit,
    FillLrc,
    FillCrcHi,
    FillCrcLo
  } fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic [8:0] idx;
    logic       done;
    status_e    st;
  } rx_result_t;

  // Hand-written answer for a directed row, in request order
  typedef struct packed {
    bit         typed;
    rx_result_t res;
  } row_note_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] reg_sel;
    fill_e              fill;
    logic [7:0]         value;
    logic               link;
    bit                 typed;
    rx_result_t         want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  t1brc_in_if  in_ch ();
  t1brc_out_if out_ch ();

  t1_block_receive_checker u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // Register shadows
  logic [7:0] cfg_nad;
  logic [7:0] cfg_ifsd;
  logic       cfg_edc;

  // Block state of the model
  rx_phase_e  rx_phase;
  logic [8:0] rx_count;
  logic [7:0] rx_nad;
  logic [7:0] rx_pcb;
  logic [7:0] rx_len;
  logic [7:0] rx_lrc;
  logic [15:0] rx_crc;
  logic [7:0] rx_crc_hi;

  rx_result_t awaited[$];
  row_note_t  row_notes[$];
  dir_row_t   dir_rows[$];

  int  errors;
  int  items_sent;
  bit  calm;   // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Model of the block
  // ---------------------------------------------------------------------------

  function automatic void clear_rx();
    rx_phase  = RxHeader;
    rx_count  = '0;
    rx_nad    = '0;
    rx_pcb    = '0;
    rx_len    = '0;
    rx_lrc    = '0;
    rx_crc    = CrcInit;
    rx_crc_hi = '0;
  endfunction

  // CRC-16, one bit at a time, MSB of the byte first
  function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return acc;
  endfunction

  // NAD / PCB / LEN rules; NAD zero passes everything
  function automatic status_e frame_rules(input logic [7:0] nad, input logic [7:0] pcb,
                                          input logic [7:0] len);
    if (nad == 8'h00) return StOk;
    if (nad == NadBcast || |(nad & NadRsvMask) || nad[7:4] == nad[3:0]) return StBadNad;
    if (pcb[7]) begin
      if (|(pcb & PcbSRsvMask)) return StBadPcb;
    end else if (pcb[6]) begin
      if (|(pcb & PcbRRsvMask)) return StBadPcb;
    end else begin
      if (|(pcb & PcbIRsvMask)) return StBadPcb;
      if (len != 8'h00) return StBadLen;
    end
    if (len == LenRsv || len > cfg_ifsd) return StBadLen;
    return StOk;
  endfunction

  // EDC first, then the echoed NAD, then the block rules
  function automatic status_e block_verdict(input bit edc_ok);
    if (!edc_ok) return StBadEdc;
    if (rx_nad != {cfg_nad[3:0], cfg_nad[7:4]}) return StBadNad;
    return frame_rules(rx_nad, rx_pcb, rx_len);
  endfunction

  function automatic rx_result_t advance_block(input logic [7:0] b, input logic link);
    rx_result_t r;
    r.data = b;
    r.idx  = rx_count;
    r.done = 1'b0;
    r.st   = StOk;
    if (link) begin
      r.data = 8'h00;
      r.done = 1'b1;
      r.st   = StLink;
      clear_rx();
      return r;
    end
    case (rx_phase)
      RxHeader: begin
        if (rx_count == 9'd0) rx_nad = b;
        else if (rx_count == 9'd1) rx_pcb = b;
        else begin
          rx_len   = b;
          rx_phase = (b == 8'h00) ? RxEdc : RxInfo;
        end
        rx_lrc = rx_lrc ^ b;
        rx_crc = crc16_shift(rx_crc, b);
      end
      RxInfo: begin
        rx_lrc = rx_lrc ^ b;
        rx_crc = crc16_shift(rx_crc, b);
        if (rx_count >= 9'd2 + {1'b0, rx_len}) rx_phase = RxEdc;
      end
      RxEdc: begin
        // check kind is taken here, at the first epilogue byte
        if (cfg_edc == EdcLrc) begin
          r.done = 1'b1;
          r.st   = block_verdict(b == rx_lrc);
        end else begin
          rx_crc_hi = b;
          rx_phase  = RxCrcLo;
        end
      end
      default: begin
        r.done = 1'b1;
        r.st   = block_verdict({rx_crc_hi, b} == rx_crc);
      end
    endcase
    if (r.done) clear_rx();
    else rx_count = rx_count + 9'd1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, sink side
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sink stalls with a chance of about 15 in 100 unless calm
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Results are checked before new requests are queued; no result leaves in the same cycle as its request
  always @(posedge clk) begin : scoreboard
    rx_result_t exp_r;
    rx_result_t model_r;
    row_note_t  note;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          errors++;
          $error("unexpected result: byte_out %0h byte_index %0d", out_ch.byte_out,
                 out_ch.byte_index);
        end else begin
          exp_r = awaited.pop_front();
          if (out_ch.byte_out !== exp_r.data) begin
            errors++;
            $error("byte_out: expected %0h, got %0h", exp_r.data, out_ch.byte_out);
          end
          if (out_ch.byte_index !== exp_r.idx) begin
            errors++;
            $error("byte_index: expected %0d, got %0d", exp_r.idx, out_ch.byte_index);
          end
          if (out_ch.block_done !== exp_r.done) begin
            errors++;
            $error("block_done: expected %0b, got %0b", exp_r.done, out_ch.block_done);
          end
          if (out_ch.status !== exp_r.st) begin
            errors++;
            $error("status: expected %0d, got %0d", exp_r.st, out_ch.status);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        // model always steps so its state stays in line with the block
        model_r = advance_block(in_ch.data_byte, in_ch.line_error);
        note = row_notes.pop_front();
        awaited.push_back(note.typed ? note.res : model_r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Entered right after a falling edge; returns right after the falling edge
  // that follows acceptance, leaving valid high for the caller to decide.
  task automatic feed_byte(input fill_e fill, input logic [7:0] lit, input logic link,
                           input bit typed, input rx_result_t want);
    logic [7:0] b;
    row_note_t  note;
    while (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    // all earlier requests are already in the model, so check bytes are current
    case (fill)
      FillLrc:   b = rx_lrc;
      FillCrcHi: b = rx_crc[15:8];
      FillCrcLo: b = rx_crc[7:0];
      default:   b = lit;
    endcase
    note.typed = typed;
    note.res   = want;
    row_notes.push_back(note);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.line_error <= link;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every result to come back
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0 || row_notes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] sel, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= sel;
    cfg_wdata <= val;
    case (sel)
      RegSentNad:   cfg_nad  = val;
      RegIfsdLimit: cfg_ifsd = val;
      RegEdcMode:   cfg_edc  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One block with random content: mostly well formed, sometimes with a bad
  // check byte or cut short by a link error
  task automatic send_block();
    logic [7:0] nad;
    logic [7:0] pcb;
    logic [7:0] len;
    logic [7:0] v;
    fill_e      f;
    int         roll;
    int         cut;
    int         total;
    bit         bad_edc;
    // resync if a broken sequence left the block mid-way
    if (rx_count != 9'd0) feed_byte(FillLit, 8'($urandom_range(255)), 1'b1, 1'b0, '0);
    nad = ($urandom_range(9) != 0) ? {cfg_nad[3:0], cfg_nad[7:4]}
                                   : 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       pcb = 8'($urandom_range(255)) & 8'h13;           // I-block
      1:       pcb = 8'h40 | (8'($urandom_range(255)) & 8'h23); // R-block
      2:       pcb = 8'h80 | (8'($urandom_range(255)) & 8'h60); // S-block
      default: pcb = 8'($urandom_range(255));
    endcase
    roll = $urandom_range(199);
    if (roll < 110) len = 8'h00;
    else if (roll < 180) len = 8'($urandom_range(1, 8));
    else if (roll < 195) len = (cfg_ifsd < 8'd16) ? cfg_ifsd + 8'($urandom_range(1))
                                                  : 8'($urandom_range(1, 8));
    else if (roll == 195) len = LenRsv;
    else len = 8'($urandom_range(255));
    cut     = ($urandom_range(19) == 0) ? $urandom_range(len + 4) : -1;
    total   = 3 + len + ((cfg_edc == EdcCrc) ? 2 : 1);
    bad_edc = ($urandom_range(9) == 0);
    for (int k = 0; k < total; k++) begin
      if (k == cut) begin
        feed_byte(FillLit, 8'($urandom_range(255)), 1'b1, 1'b0, '0);
        return;
      end
      f = FillLit;
      v = 8'($urandom_range(255));
      if (k == 0) v = nad;
      else if (k == 1) v = pcb;
      else if (k == 2) v = len;
      else if (k >= 3 + len) begin
        if (bad_edc && k == total - 1) f = FillLit;
        else if (cfg_edc == EdcLrc) f = FillLrc;
        else f = (k == 3 + len) ? FillCrcHi : FillCrcLo;
      end
      feed_byte(f, v, 1'b0, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t byte_row(input fill_e f, input logic [7:0] v, input logic link,
                                        input bit typed, input logic [8:0] idx,
                                        input logic done, input status_e st);
    dir_row_t r;
    r.is_cfg    = 1'b0;
    r.reg_sel   = RegSentNad;
    r.fill      = f;
    r.value     = v;
    r.link      = link;
    r.typed     = typed;
    r.want.data = link ? 8'h00 : v;
    r.want.idx  = idx;
    r.want.done = done;
    r.want.st   = st;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] sel, input logic [7:0] v);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.value   = v;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int ph;
    int start;
    int n;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = RegSentNad;
    cfg_wdata        = 8'h00;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.line_error = 1'b0;
    errors           = 0;
    items_sent       = 0;
    calm             = 1'b0;
    cfg_nad          = 8'h00;
    cfg_ifsd         = IfsdLimitRst;
    cfg_edc          = EdcLrc;
    clear_rx();

    // NAD zero with a reserved PCB still passes; empty info field
    dir_rows.push_back(byte_row(FillLit, 8'h00, 1'b0, 1'b1, 9'd0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'hFF, 1'b0, 1'b1, 9'd1, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h00, 1'b0, 1'b1, 9'd2, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'hFF, 1'b0, 1'b1, 9'd3, 1'b1, StOk));
    // link error on the first byte and in the middle of a block
    dir_rows.push_back(byte_row(FillLit, 8'hA5, 1'b1, 1'b1, 9'd0, 1'b1, StLink));
    dir_rows.push_back(byte_row(FillLit, 8'hFF, 1'b0, 1'b1, 9'd0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h5A, 1'b1, 1'b1, 9'd1, 1'b1, StLink));
    // wrong LRC
    dir_rows.push_back(byte_row(FillLit, 8'h00, 1'b0, 1'b1, 9'd0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h00, 1'b0, 1'b1, 9'd1, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h00, 1'b0, 1'b1, 9'd2, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h55, 1'b0, 1'b1, 9'd3, 1'b1, StBadEdc));
    // good S-block with one info byte, largest limit
    dir_rows.push_back(cfg_row(RegSentNad, 8'h21));
    dir_rows.push_back(cfg_row(RegIfsdLimit, 8'd254));
    dir_rows.push_back(byte_row(FillLit, 8'h12, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h80, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h01, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h5A, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLrc, 8'h00, 1'b0, 1'b0, '0, 1'b0, StOk));
    // CRC mode, bad S-block PCB; mode flips back to LRC after the CRC high
    // byte, yet the next byte is still taken as the CRC low byte
    dir_rows.push_back(cfg_row(RegIfsdLimit, 8'd0));
    dir_rows.push_back(cfg_row(RegEdcMode, {7'd0, EdcCrc}));
    dir_rows.push_back(byte_row(FillLit, 8'h12, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h81, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillLit, 8'h00, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(byte_row(FillCrcHi, 8'h00, 1'b0, 1'b0, '0, 1'b0, StOk));
    dir_rows.push_back(cfg_row(RegEdcMode, {7'd0, EdcLrc}));
    dir_rows.push_back(byte_row(FillCrcLo, 8'h00, 1'b0, 1'b0, '0, 1'b0, StOk));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        quiesce();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        feed_byte(dir_rows[i].fill, dir_rows[i].value, dir_rows[i].link, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    // Random phases, each with its own register setting; the first two take
    // the extremes, phase 3 runs without any idling
    for (ph = 0; ph < 8; ph++) begin
      quiesce();
      case (ph)
        0: begin
          write_reg(RegSentNad, 8'hFF);
          write_reg(RegIfsdLimit, 8'd254);
          write_reg(RegEdcMode, {7'd0, EdcCrc});
        end
        1: begin
          write_reg(RegSentNad, 8'h00);
          write_reg(RegIfsdLimit, 8'd0);
          write_reg(RegEdcMode, {7'd0, EdcLrc});
        end
        default: begin
          // masked NADs swap into legal ones more often
          write_reg(RegSentNad, $urandom_range(1) ? (8'($urandom_range(255)) & 8'h77)
                                                  : 8'($urandom_range(255)));
          write_reg(RegIfsdLimit, 8'($urandom_range(254)));
          write_reg(RegEdcMode, 8'($urandom_range(1)));
        end
      endcase
      calm  = (ph == 3);
      start = items_sent;
      while (items_sent - start < 85) begin
        if ($urandom_range(9) < 8) begin
          send_block();
        end else begin
          // noise: stray bytes with the odd link error
          n = $urandom_range(1, 6);
          repeat (n) feed_byte(FillLit, 8'($urandom_range(255)), $urandom_range(9) == 0,
                               1'b0, '0);
        end
      end
    end
    calm = 1'b0;

    quiesce();
    // wait on to catch any stray result
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS t1_block_receive_checker");
    end else begin
      $display("FAIL t1_block_receive_checker");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL t1_block_receive_checker");
    $finish;
  end

endmodule
